// ----- sv/strz_pkg.sv -----
// Shared types and constants of the scanline rasteriser with depth buffer.
// Used by the sequencer, the multiply/divide unit and the top level.
`timescale 1ns / 1ps
package strz_pkg;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_DRAW  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam logic [0:0] CFG_CLEAR_COLOR = 1'd0;
    localparam logic [0:0] CFG_CLEAR_DEPTH = 1'd1;

    localparam logic MD_MUL = 1'b0;
    localparam logic MD_DIV = 1'b1;

    localparam logic [5:0] MD_MUL_STEPS = 6'd32;
    localparam logic [5:0] MD_DIV_STEPS = 6'd48;
    localparam int         MD_DIV_W     = 48;

    localparam int ROW_W = 14;
    localparam int XC_W  = 17;
    localparam int MEM_W = 56;

    localparam logic signed [23:0] DEPTH_RESET = 24'sd25600;
    localparam logic [12:0]        COUNT_MAX   = 13'd8191;

    typedef struct packed {
        logic [1:0]          operation;
        logic signed [19:0]  v0_x;
        logic signed [19:0]  v0_y;
        logic signed [23:0]  v0_z;
        logic signed [19:0]  v1_x;
        logic signed [19:0]  v1_y;
        logic signed [23:0]  v1_z;
        logic signed [19:0]  v2_x;
        logic signed [19:0]  v2_y;
        logic signed [23:0]  v2_z;
        logic [31:0]         draw_color;
        logic [11:0]         pixel_index;
    } req_item_t;

    typedef struct packed {
        logic [31:0]         pixel_color;
        logic signed [23:0]  pixel_depth;
        logic [12:0]         fragments_written;
    } rsp_item_t;

    typedef struct packed {
        logic signed [19:0]  x;
        logic signed [19:0]  y;
        logic signed [23:0]  z;
    } vtx_t;

    typedef struct packed {
        logic                start;
        logic                op;
        logic signed [63:0]  a;
        logic signed [63:0]  b;
    } md_req_t;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic signed [63:0]  result;
    } md_rsp_t;

endpackage

// ----- sv/scanline_triangle_raster_zbuffer_unit.sv -----
// A clear sweeps every pixel; a read fetches one RAM word. Per row a draw runs
//   up to four multiply/divide pairs for the edge ends, one divide and one
//   multiply for span slope and start depth, all in the shared unit, then a
//   read and a depth test per pixel. One item at a time; the next item is taken
// once the result is in the output register. After reset a sweep fills the
// framebuffer (colour 0, depth 100.0) before the first item; config resets too.
`timescale 1ns / 1ps
module scanline_triangle_raster_zbuffer_unit #(
    parameter int IMAGE_WIDTH  = 64,
    parameter int IMAGE_HEIGHT = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  strz_pkg::req_item_t req_item,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output strz_pkg::rsp_item_t rsp_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [0:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    localparam int PIX = IMAGE_WIDTH * IMAGE_HEIGHT;
    localparam int AW  = (PIX > 1) ? $clog2(PIX) : 1;

    logic [31:0]                clear_color_reg, clear_color_next;
    logic signed [23:0]         clear_depth_reg, clear_depth_next;
    logic                       out_valid_reg, out_valid_next;
    strz_pkg::rsp_item_t        out_item_reg, out_item_next;

    logic                       seq_ready, res_valid, res_ready;
    strz_pkg::rsp_item_t        res;
    strz_pkg::md_req_t          md_req;
    strz_pkg::md_rsp_t          md_rsp;
    logic                       ram_we, ram_re;
    logic [AW-1:0]              ram_waddr, ram_raddr;
    logic [strz_pkg::MEM_W-1:0] ram_wdata, ram_rdata;

    assign cfg_ready = 1'b1;
    assign req_ready = seq_ready;
    // hand over only when the output register is free or being emptied
    assign res_ready = !out_valid_reg || rsp_ready;

    always_comb
    begin
        clear_color_next = clear_color_reg;
        clear_depth_next = clear_depth_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                strz_pkg::CFG_CLEAR_COLOR: clear_color_next = cfg_data;
                strz_pkg::CFG_CLEAR_DEPTH: clear_depth_next = cfg_data[23:0];
            endcase
        end
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_item_next  = res;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_color_reg <= '0;
            clear_depth_reg <= strz_pkg::DEPTH_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            clear_color_reg <= clear_color_next;
            clear_depth_reg <= clear_depth_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_item  = out_item_reg;

    strz_ram #(
        .WIDTH (strz_pkg::MEM_W),
        .DEPTH (PIX)
    ) u_fb (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    strz_muldiv u_md (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .rsp   (md_rsp)
    );

    strz_seq #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (req_valid && req_ready),
        .item        (req_item),
        .ready       (seq_ready),
        .clear_color (clear_color_reg),
        .clear_depth (clear_depth_reg),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .md_req      (md_req),
        .md_rsp      (md_rsp),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata)
    );

`ifndef SYNTH
    a_md_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        md_req.start |-> !md_rsp.busy)
        else $error("mul/div started while busy");

    a_ready_unit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready |-> (!md_rsp.busy && !md_rsp.done))
        else $error("item taken while the arithmetic unit is active");

    a_read_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready) |->
            (res.fragments_written == 13'd0
             || (res.pixel_color == 32'd0 && res.pixel_depth == 24'sd0)))
        else $error("result carries both pixel data and a fragment count");

    a_load_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready) |=> rsp_valid)
        else $error("finished result not shown at the output");
`endif

endmodule

// ----- sv/strz_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module strz_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- sv/strz_muldiv.sv -----
// Shared bit-serial multiply and restoring divide unit, signed, truncating.
// Depends on strz_pkg for the request and response structs.
`timescale 1ns / 1ps
module strz_muldiv (
    input  logic              clk,
    input  logic              rst_n,
    input  strz_pkg::md_req_t req,
    output strz_pkg::md_rsp_t rsp
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic        op_reg, op_next;
    logic        neg_reg, neg_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] ma_reg, ma_next;
    logic [63:0] mb_reg, mb_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] rem_s;
    logic        ge;
    logic [63:0] mag;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        ma_next   = ma_reg;
        mb_next   = mb_reg;
        acc_next  = acc_reg;
        rem_s     = {acc_reg[62:0], ma_reg[strz_pkg::MD_DIV_W-1]};
        ge        = (rem_s >= mb_reg);
        if (req.start)
        begin
            busy_next = 1'b1;
            op_next   = req.op;
            neg_next  = req.a[63] ^ req.b[63];
            ma_next   = req.a[63] ? 64'(-req.a) : 64'(req.a);
            mb_next   = req.b[63] ? 64'(-req.b) : 64'(req.b);
            acc_next  = '0;
            cnt_next  = (req.op == strz_pkg::MD_DIV) ? strz_pkg::MD_DIV_STEPS
                                                     : strz_pkg::MD_MUL_STEPS;
        end
        else if (busy_reg)
        begin
            if (op_reg == strz_pkg::MD_MUL)
            begin
                if (mb_reg[0])
                begin
                    acc_next = acc_reg + ma_reg;
                end
                ma_next = {ma_reg[62:0], 1'b0};
                mb_next = {1'b0, mb_reg[63:1]};
            end
            else
            begin
                acc_next = ge ? (rem_s - mb_reg) : rem_s;
                ma_next  = {ma_reg[62:0], ge};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        ma_reg  <= ma_next;
        mb_reg  <= mb_next;
        acc_reg <= acc_next;
    end

    assign mag = (op_reg == strz_pkg::MD_DIV) ? 64'(ma_reg[strz_pkg::MD_DIV_W-1:0])
                                               : acc_reg;
    assign rsp.busy   = busy_reg;
    assign rsp.done   = done_reg;
    assign rsp.result = neg_reg ? $signed(-mag) : $signed(mag);

endmodule

// ----- sv/strz_seq.sv -----
// Sequencer: framebuffer sweeps, pixel reads and the scanline walk of a draw.
// Depends on strz_pkg; drives the framebuffer RAM and the shared mul/div unit.
`timescale 1ns / 1ps
module strz_seq #(
    parameter int IMAGE_WIDTH  = 64,
    parameter int IMAGE_HEIGHT = 64,
    localparam int PIX = IMAGE_WIDTH * IMAGE_HEIGHT,
    localparam int AW  = (PIX > 1) ? $clog2(PIX) : 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  strz_pkg::req_item_t        item,
    output logic                       ready,
    input  logic [31:0]                clear_color,
    input  logic signed [23:0]         clear_depth,
    output logic                       res_valid,
    input  logic                       res_ready,
    output strz_pkg::rsp_item_t        res,
    output strz_pkg::md_req_t          md_req,
    input  strz_pkg::md_rsp_t          md_rsp,
    output logic                       ram_we,
    output logic [AW-1:0]              ram_waddr,
    output logic [strz_pkg::MEM_W-1:0] ram_wdata,
    output logic                       ram_re,
    output logic [AW-1:0]              ram_raddr,
    input  logic [strz_pkg::MEM_W-1:0] ram_rdata
);

    localparam int RW = strz_pkg::ROW_W;
    localparam int CW = strz_pkg::XC_W;

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_CLEAR = 4'd2;
    localparam logic [3:0] S_READW = 4'd3;
    localparam logic [3:0] S_PREP  = 4'd4;
    localparam logic [3:0] S_ROW   = 4'd5;
    localparam logic [3:0] S_EOP   = 4'd6;
    localparam logic [3:0] S_MULW  = 4'd7;
    localparam logic [3:0] S_DIVW  = 4'd8;
    localparam logic [3:0] S_SPAN  = 4'd9;
    localparam logic [3:0] S_DELW  = 4'd10;
    localparam logic [3:0] S_STW   = 4'd11;
    localparam logic [3:0] S_PIX   = 4'd12;
    localparam logic [3:0] S_PIXW  = 4'd13;
    localparam logic [3:0] S_DONE  = 4'd14;

    localparam logic [AW-1:0]        LAST_ADDR   = AW'(PIX - 1);
    localparam logic [12:0]          CLEAR_COUNT = (PIX > 8191) ? 13'd8191 : 13'(PIX);
    localparam logic signed [RW-1:0] H_ROW       = RW'(IMAGE_HEIGHT);
    localparam logic signed [RW-1:0] ROW_ONE     = RW'(1);
    localparam logic signed [CW-1:0] W_COL       = CW'(IMAGE_WIDTH);
    localparam logic signed [CW-1:0] COL_ONE     = CW'(1);

    function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
        if (v > 64'sd8388607)
            return 24'sd8388607;
        else if (v < -64'sd8388608)
            return -24'sd8388608;
        else
            return v[23:0];
    endfunction

    function automatic logic signed [RW-1:0] q8_row(input logic signed [19:0] v);
        logic signed [20:0] t;
        t = 21'(v) + (v[19] ? 21'sd255 : 21'sd0);
        return RW'(t >>> 8);
    endfunction

    function automatic logic signed [CW-1:0] q8_col(input logic signed [23:0] v);
        logic signed [24:0] t;
        t = 25'(v) + (v[23] ? 25'sd255 : 25'sd0);
        return CW'(t >>> 8);
    endfunction

    logic [3:0]              state_reg, state_next;
    logic [AW-1:0]           sweep_reg, sweep_next;
    strz_pkg::vtx_t          va_reg, va_next, vb_reg, vb_next, vc_reg, vc_next;
    logic [31:0]             color_reg, color_next;
    logic signed [RW-1:0]    y_reg, y_next;
    logic                    half_reg, half_next;
    logic                    e_reg, e_next;
    logic                    part_reg, part_next;
    logic signed [23:0]      ex0_reg, ex0_next, ex1_reg, ex1_next;
    logic signed [23:0]      ez0_reg, ez0_next, ez1_reg, ez1_next;
    logic signed [23:0]      lx_reg, lx_next, lz_reg, lz_next;
    logic signed [CW-1:0]    x_reg, x_next, xe_reg, xe_next;
    logic signed [63:0]      delta_reg, delta_next;
    logic signed [63:0]      depth_reg, depth_next;
    logic [AW-1:0]           row_base_reg, row_base_next;
    logic [12:0]             cnt_reg, cnt_next;
    logic [31:0]             rcolor_reg, rcolor_next;
    logic signed [23:0]      rdepth_reg, rdepth_next;

    strz_pkg::vtx_t          p0, p1, p2, s0, s1, s2;
    logic signed [RW-1:0]    y0_row, y1_row, y2_row, yt0, yt1, yt2;
    strz_pkg::vtx_t          base;
    logic signed [20:0]      dxs, dys;
    logic signed [24:0]      dzs;
    logic signed [22:0]      dy_e;
    logic signed [63:0]      edge_sum, p_res;
    logic signed [23:0]      e_val, lx_s, lz_s, rx_s, rz_s, d_new, d_old;
    logic signed [CW-1:0]    xs_raw, xe_raw;
    logic [31:0]             row_prod;
    logic [AW-1:0]           pix_addr;

    // sort by y with the three strict compare-and-swap steps
    always_comb
    begin
        p0.x = item.v0_x;
        p0.y = item.v0_y;
        p0.z = item.v0_z;
        p1.x = item.v1_x;
        p1.y = item.v1_y;
        p1.z = item.v1_z;
        p2.x = item.v2_x;
        p2.y = item.v2_y;
        p2.z = item.v2_z;
        s0 = p0;
        s1 = p1;
        s2 = p2;
        if (p0.y > p1.y)
        begin
            s0 = p1;
            s1 = p0;
        end
        if (s0.y > p2.y)
        begin
            s2 = s0;
            s0 = p2;
        end
        if (s1.y > s2.y)
        begin
            p0 = s1;
            s1 = s2;
            s2 = p0;
        end
    end

    assign yt0    = q8_row(va_reg.y);
    assign yt1    = q8_row(vb_reg.y);
    assign yt2    = q8_row(vc_reg.y);
    assign y0_row = (yt0 < 0) ? '0 : yt0;
    assign y1_row = (yt1 < 0) ? '0 : ((yt1 > H_ROW) ? H_ROW : yt1);
    assign y2_row = (yt2 > H_ROW) ? H_ROW : yt2;

    // edge under work: min->max, then min->mid (lower) or max->mid (upper)
    always_comb
    begin
        if (!e_reg)
        begin
            base = va_reg;
            dxs  = 21'(vc_reg.x) - 21'(va_reg.x);
            dys  = 21'(vc_reg.y) - 21'(va_reg.y);
            dzs  = 25'(vc_reg.z) - 25'(va_reg.z);
        end
        else if (!half_reg)
        begin
            base = va_reg;
            dxs  = 21'(vb_reg.x) - 21'(va_reg.x);
            dys  = 21'(vb_reg.y) - 21'(va_reg.y);
            dzs  = 25'(vb_reg.z) - 25'(va_reg.z);
        end
        else
        begin
            base = vc_reg;
            dxs  = 21'(vc_reg.x) - 21'(vb_reg.x);
            dys  = 21'(vc_reg.y) - 21'(vb_reg.y);
            dzs  = 25'(vc_reg.z) - 25'(vb_reg.z);
        end
    end

    assign dy_e     = (23'(y_reg) <<< 8) - 23'(base.y);
    assign edge_sum = (part_reg ? 64'(base.z) : 64'(base.x)) + md_rsp.result;
    assign e_val    = sat24(edge_sum);
    assign lx_s     = (ex1_reg < ex0_reg) ? ex1_reg : ex0_reg;
    assign lz_s     = (ex1_reg < ex0_reg) ? ez1_reg : ez0_reg;
    assign rx_s     = (ex1_reg < ex0_reg) ? ex0_reg : ex1_reg;
    assign rz_s     = (ex1_reg < ex0_reg) ? ez0_reg : ez1_reg;
    assign xs_raw   = q8_col(lx_s);
    assign xe_raw   = q8_col(rx_s);
    assign p_res    = md_rsp.result;
    assign d_new    = sat24(depth_reg);
    assign d_old    = ram_rdata[23:0];
    assign row_prod = 32'(y_reg) * 32'(IMAGE_WIDTH);
    assign pix_addr = row_base_reg + AW'(x_reg);

    always_comb
    begin
        state_next    = state_reg;
        sweep_next    = sweep_reg;
        va_next       = va_reg;
        vb_next       = vb_reg;
        vc_next       = vc_reg;
        color_next    = color_reg;
        y_next        = y_reg;
        half_next     = half_reg;
        e_next        = e_reg;
        part_next     = part_reg;
        ex0_next      = ex0_reg;
        ex1_next      = ex1_reg;
        ez0_next      = ez0_reg;
        ez1_next      = ez1_reg;
        lx_next       = lx_reg;
        lz_next       = lz_reg;
        x_next        = x_reg;
        xe_next       = xe_reg;
        delta_next    = delta_reg;
        depth_next    = depth_reg;
        row_base_next = row_base_reg;
        cnt_next      = cnt_reg;
        rcolor_next   = rcolor_reg;
        rdepth_next   = rdepth_reg;
        md_req        = '0;
        ram_we        = 1'b0;
        ram_waddr     = sweep_reg;
        ram_wdata     = {clear_color, clear_depth};
        ram_re        = 1'b0;
        ram_raddr     = pix_addr;
        res_valid     = 1'b0;

        unique case (state_reg)
            S_INIT:
            begin
                ram_we    = 1'b1;
                ram_wdata = {32'd0, strz_pkg::DEPTH_RESET};
                sweep_next = sweep_reg + AW'(1);
                if (sweep_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    rcolor_next = '0;
                    rdepth_next = '0;
                    cnt_next    = '0;
                    sweep_next  = '0;
                    unique case (item.operation)
                        strz_pkg::OP_CLEAR: state_next = S_CLEAR;
                        strz_pkg::OP_DRAW:
                        begin
                            va_next    = s0;
                            vb_next    = s1;
                            vc_next    = s2;
                            color_next = item.draw_color;
                            state_next = S_PREP;
                        end
                        strz_pkg::OP_READ:
                        begin
                            if (32'(item.pixel_index) < 32'(PIX))
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = AW'(item.pixel_index);
                                state_next = S_READW;
                            end
                            else
                            begin
                                state_next = S_DONE;
                            end
                        end
                        strz_pkg::OP_NONE: state_next = S_DONE;
                    endcase
                end
            end
            S_CLEAR:
            begin
                ram_we     = 1'b1;
                sweep_next = sweep_reg + AW'(1);
                if (sweep_reg == LAST_ADDR)
                begin
                    cnt_next   = CLEAR_COUNT;
                    state_next = S_DONE;
                end
            end
            S_READW:
            begin
                rcolor_next = ram_rdata[55:24];
                rdepth_next = ram_rdata[23:0];
                state_next  = S_DONE;
            end
            S_PREP:
            begin
                y_next     = y0_row;
                half_next  = 1'b0;
                state_next = S_ROW;
            end
            S_ROW:
            begin
                if (!half_reg && y_reg >= y1_row)
                begin
                    half_next = 1'b1;
                    y_next    = y1_row;
                end
                else if (half_reg && y_reg >= y2_row)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    row_base_next = AW'(row_prod);
                    e_next        = 1'b0;
                    part_next     = 1'b0;
                    state_next    = S_EOP;
                end
            end
            S_EOP:
            begin
                if (dys == 21'sd0)
                begin
                    // flat edge: the end point is the base vertex
                    if (!e_reg)
                    begin
                        ex0_next = 24'(base.x);
                        ez0_next = base.z;
                        e_next   = 1'b1;
                    end
                    else
                    begin
                        ex1_next   = 24'(base.x);
                        ez1_next   = base.z;
                        state_next = S_SPAN;
                    end
                    part_next = 1'b0;
                end
                else
                begin
                    md_req.start = 1'b1;
                    md_req.op    = strz_pkg::MD_MUL;
                    md_req.a     = part_reg ? 64'(dzs) : 64'(dxs);
                    md_req.b     = 64'(dy_e);
                    state_next   = S_MULW;
                end
            end
            S_MULW:
            begin
                if (md_rsp.done)
                begin
                    md_req.start = 1'b1;
                    md_req.op    = strz_pkg::MD_DIV;
                    md_req.a     = md_rsp.result;
                    md_req.b     = 64'(dys);
                    state_next   = S_DIVW;
                end
            end
            S_DIVW:
            begin
                if (md_rsp.done)
                begin
                    if (!part_reg)
                    begin
                        if (!e_reg)
                            ex0_next = e_val;
                        else
                            ex1_next = e_val;
                        part_next  = 1'b1;
                        state_next = S_EOP;
                    end
                    else
                    begin
                        if (!e_reg)
                            ez0_next = e_val;
                        else
                            ez1_next = e_val;
                        part_next = 1'b0;
                        if (e_reg)
                        begin
                            state_next = S_SPAN;
                        end
                        else
                        begin
                            e_next     = 1'b1;
                            state_next = S_EOP;
                        end
                    end
                end
            end
            S_SPAN:
            begin
                if (rx_s == lx_s)
                begin
                    // zero-width span: drop the row
                    y_next     = y_reg + ROW_ONE;
                    state_next = S_ROW;
                end
                else
                begin
                    lx_next      = lx_s;
                    lz_next      = lz_s;
                    x_next       = (xs_raw < 0) ? '0 : xs_raw;
                    xe_next      = (xe_raw > W_COL) ? W_COL : xe_raw;
                    md_req.start = 1'b1;
                    md_req.op    = strz_pkg::MD_DIV;
                    md_req.a     = (64'(rz_s) - 64'(lz_s)) <<< 8;
                    md_req.b     = 64'(rx_s) - 64'(lx_s);
                    state_next   = S_DELW;
                end
            end
            S_DELW:
            begin
                if (md_rsp.done)
                begin
                    delta_next   = md_rsp.result;
                    md_req.start = 1'b1;
                    md_req.op    = strz_pkg::MD_MUL;
                    md_req.a     = md_rsp.result;
                    md_req.b     = (64'(x_reg) <<< 8) - 64'(lx_reg);
                    state_next   = S_STW;
                end
            end
            S_STW:
            begin
                if (md_rsp.done)
                begin
                    depth_next = 64'(lz_reg)
                               + ((p_res + (p_res[63] ? 64'sd255 : 64'sd0)) >>> 8);
                    state_next = S_PIX;
                end
            end
            S_PIX:
            begin
                if (x_reg < xe_reg)
                begin
                    ram_re     = 1'b1;
                    state_next = S_PIXW;
                end
                else
                begin
                    y_next     = y_reg + ROW_ONE;
                    state_next = S_ROW;
                end
            end
            S_PIXW:
            begin
                if (d_new < d_old)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pix_addr;
                    ram_wdata = {color_reg, d_new};
                    if (cnt_reg != strz_pkg::COUNT_MAX)
                    begin
                        cnt_next = cnt_reg + 13'd1;
                    end
                end
                // depth steps on every pixel, written or not
                depth_next = depth_reg + delta_reg;
                x_next     = x_reg + COL_ONE;
                state_next = S_PIX;
            end
            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            sweep_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
        end
    end

    always_ff @(posedge clk)
    begin
        va_reg       <= va_next;
        vb_reg       <= vb_next;
        vc_reg       <= vc_next;
        color_reg    <= color_next;
        y_reg        <= y_next;
        half_reg     <= half_next;
        e_reg        <= e_next;
        part_reg     <= part_next;
        ex0_reg      <= ex0_next;
        ex1_reg      <= ex1_next;
        ez0_reg      <= ez0_next;
        ez1_reg      <= ez1_next;
        lx_reg       <= lx_next;
        lz_reg       <= lz_next;
        x_reg        <= x_next;
        xe_reg       <= xe_next;
        delta_reg    <= delta_next;
        depth_reg    <= depth_next;
        row_base_reg <= row_base_next;
        cnt_reg      <= cnt_next;
        rcolor_reg   <= rcolor_next;
        rdepth_reg   <= rdepth_next;
    end

    assign ready                 = (state_reg == S_IDLE);
    assign res.pixel_color       = rcolor_reg;
    assign res.pixel_depth       = rdepth_reg;
    assign res.fragments_written = cnt_reg;

endmodule

// ----- tb/sv/strz_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the scanline rasteriser: keeps its own colour/depth framebuffer,
// predicts each result from accepted items and register writes, and compares.
// Depends on strz_pkg for the item types and operation codes.
module strz_checker #(
    parameter int IMAGE_WIDTH  = 64,
    parameter int IMAGE_HEIGHT = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_ready,
    input  strz_pkg::req_item_t req_item,
    input  logic                rsp_valid,
    input  logic                rsp_ready,
    input  strz_pkg::rsp_item_t rsp_item,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [0:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    output int                  pending,
    output int                  fail_count
);

    localparam int PIX = IMAGE_WIDTH * IMAGE_HEIGHT;
    localparam longint D_MAX = 8388607;
    localparam longint D_MIN = -8388608;

    typedef struct {
        longint x;
        longint y;
        longint z;
    } pt_t;

    logic [31:0]         fb_color [PIX];
    logic signed [23:0]  fb_depth [PIX];
    logic [31:0]         clr_color;
    logic signed [23:0]  clr_depth;
    strz_pkg::rsp_item_t expected_pixels [$];

    function automatic longint clamp24(longint v);
        if (v > D_MAX) return D_MAX;
        if (v < D_MIN) return D_MIN;
        return v;
    endfunction

    function automatic pt_t edge_point(longint yq, pt_t b, pt_t d);
        pt_t e;
        longint dy;
        dy = yq - b.y;
        if (d.y == 0)
        begin
            e.x = clamp24(b.x);
            e.z = clamp24(b.z);
        end
        else
        begin
            e.x = clamp24(b.x + (d.x * dy) / d.y);
            e.z = clamp24(b.z + (d.z * dy) / d.y);
        end
        e.y = yq;
        return e;
    endfunction

    function automatic int fill_row(longint y, pt_t b1, pt_t d1, pt_t b2, pt_t d2,
                                    logic [31:0] colour);
        pt_t lft, rgt, tmp;
        longint xs, xe, slope, run_z, x, dz;
        int n;
        n = 0;
        lft = edge_point(y * 256, b1, d1);
        rgt = edge_point(y * 256, b2, d2);
        if (rgt.x < lft.x)
        begin
            tmp = lft; lft = rgt; rgt = tmp;
        end
        if (rgt.x == lft.x) return 0;
        xs = lft.x / 256;
        if (xs < 0) xs = 0;
        xe = rgt.x / 256;
        if (xe > IMAGE_WIDTH) xe = IMAGE_WIDTH;
        slope = ((rgt.z - lft.z) * 256) / (rgt.x - lft.x);
        run_z = lft.z + (slope * (xs * 256 - lft.x)) / 256;
        for (x = xs; x < xe; x++)
        begin
            dz = clamp24(run_z);
            if (dz < longint'(fb_depth[y * IMAGE_WIDTH + x]))
            begin
                fb_color[y * IMAGE_WIDTH + x] = colour;
                fb_depth[y * IMAGE_WIDTH + x] = dz[23:0];
                n++;
            end
            run_z += slope;
        end
        return n;
    endfunction

    function automatic pt_t pt_diff(pt_t a, pt_t b);
        pt_t r;
        r.x = a.x - b.x; r.y = a.y - b.y; r.z = a.z - b.z;
        return r;
    endfunction

    function automatic int raster_triangle(strz_pkg::req_item_t it);
        pt_t a, b, c, t;
        longint y0, y1, y2, y;
        int n;
        n = 0;
        a.x = longint'(it.v0_x); a.y = longint'(it.v0_y); a.z = longint'(it.v0_z);
        b.x = longint'(it.v1_x); b.y = longint'(it.v1_y); b.z = longint'(it.v1_z);
        c.x = longint'(it.v2_x); c.y = longint'(it.v2_y); c.z = longint'(it.v2_z);
        if (a.y > b.y)
        begin
            t = a; a = b; b = t;
        end
        if (a.y > c.y)
        begin
            t = a; a = c; c = t;
        end
        if (b.y > c.y)
        begin
            t = b; b = c; c = t;
        end
        y0 = a.y / 256; if (y0 < 0) y0 = 0;
        y1 = b.y / 256; if (y1 < 0) y1 = 0;
        if (y1 > IMAGE_HEIGHT) y1 = IMAGE_HEIGHT;
        y2 = c.y / 256; if (y2 > IMAGE_HEIGHT) y2 = IMAGE_HEIGHT;
        for (y = y0; y < y1; y++)
            n += fill_row(y, a, pt_diff(c, a), a, pt_diff(b, a), it.draw_color);
        for (y = y1; y < y2; y++)
            n += fill_row(y, a, pt_diff(c, a), c, pt_diff(c, b), it.draw_color);
        return n;
    endfunction

    function automatic strz_pkg::rsp_item_t predict_pixel_op(strz_pkg::req_item_t it);
        strz_pkg::rsp_item_t r;
        int n;
        r = '0;
        n = 0;
        case (it.operation)
            strz_pkg::OP_CLEAR:
            begin
                for (int i = 0; i < PIX; i++)
                begin
                    fb_color[i] = clr_color;
                    fb_depth[i] = clr_depth;
                end
                n = PIX;
            end
            strz_pkg::OP_DRAW:
                n = raster_triangle(it);
            strz_pkg::OP_READ:
            begin
                if (it.pixel_index < PIX)
                begin
                    r.pixel_color = fb_color[it.pixel_index];
                    r.pixel_depth = fb_depth[it.pixel_index];
                end
            end
            default: ;
        endcase
        r.fragments_written = (n > int'(strz_pkg::COUNT_MAX)) ? strz_pkg::COUNT_MAX
                                                              : n[12:0];
        return r;
    endfunction

    assign pending = expected_pixels.size();

    always @(posedge clk or negedge rst_n)
    begin
        strz_pkg::rsp_item_t want;
        if (!rst_n)
        begin
            clr_color <= '0;
            clr_depth <= strz_pkg::DEPTH_RESET;
            for (int i = 0; i < PIX; i++)
            begin
                fb_color[i] = '0;
                fb_depth[i] = strz_pkg::DEPTH_RESET;
            end
            expected_pixels.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == strz_pkg::CFG_CLEAR_COLOR) clr_color <= cfg_data;
                else clr_depth <= cfg_data[23:0];
            end
            if (rsp_valid && rsp_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("unexpected result item %p", rsp_item);
                    fail_count++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (rsp_item.pixel_color !== want.pixel_color)
                    begin
                        $error("pixel_color: expected %h, got %h",
                               want.pixel_color, rsp_item.pixel_color);
                        fail_count++;
                    end
                    if (rsp_item.pixel_depth !== want.pixel_depth)
                    begin
                        $error("pixel_depth: expected %0d, got %0d",
                               want.pixel_depth, rsp_item.pixel_depth);
                        fail_count++;
                    end
                    if (rsp_item.fragments_written !== want.fragments_written)
                    begin
                        $error("fragments_written: expected %0d, got %0d",
                               want.fragments_written, rsp_item.fragments_written);
                        fail_count++;
                    end
                end
            end
            if (req_valid && req_ready)
                expected_pixels.push_back(predict_pixel_op(req_item));
        end
    end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// Top of the rasteriser testbench: clock, reset, register writes and item stimulus.
// Depends on strz_pkg, scanline_triangle_raster_zbuffer_unit and strz_checker.
module testbench;

    logic                clk;
    logic                rst_n;
    logic                req_valid;
    logic                req_ready;
    strz_pkg::req_item_t req_item;
    logic                rsp_valid;
    logic                rsp_ready;
    strz_pkg::rsp_item_t rsp_item;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [0:0]          cfg_index;
    logic [31:0]         cfg_data;
    logic                calm;
    int                  pending;
    int                  fail_count;
    longint              cycles = 0;

    scanline_triangle_raster_zbuffer_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req_item(req_item),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_item(rsp_item),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    strz_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req_item(req_item),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_item(rsp_item),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .pending(pending), .fail_count(fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Run limit: small triangles dominate, a few cover the whole frame.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 4000000)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
        rsp_ready <= calm || ($urandom_range(99) >= 12);

    task automatic send_item(strz_pkg::req_item_t it);
        while (!calm && $urandom_range(99) < 12)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_item  <= it;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [31:0] val);
        req_valid <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Hold the sender until every result has come back.
    task automatic drain;
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic strz_pkg::req_item_t tri_item(int x0, int y0, int x1, int y1,
                                                     int x2, int y2,
                                                     int z0, int z1, int z2,
                                                     logic [31:0] colour);
        strz_pkg::req_item_t it;
        it = '0;
        it.operation = strz_pkg::OP_DRAW;
        it.v0_x = 20'(x0); it.v0_y = 20'(y0); it.v0_z = 24'(z0);
        it.v1_x = 20'(x1); it.v1_y = 20'(y1); it.v1_z = 24'(z1);
        it.v2_x = 20'(x2); it.v2_y = 20'(y2); it.v2_z = 24'(z2);
        it.draw_color = colour;
        it.pixel_index = 12'($urandom);
        return it;
    endfunction

    function automatic strz_pkg::req_item_t read_item(logic [11:0] idx);
        strz_pkg::req_item_t it;
        it = '0;
        it.operation = strz_pkg::OP_READ;
        it.pixel_index = idx;
        return it;
    endfunction

    function automatic strz_pkg::req_item_t op_item(logic [1:0] op);
        strz_pkg::req_item_t it;
        it = '0;
        it.operation = op;
        return it;
    endfunction

    // Small triangle somewhere around the frame, fractional positions included.
    function automatic strz_pkg::req_item_t small_tri();
        int bx, by, span_px;
        bx = ($urandom_range(80) - 8) * 256;
        by = ($urandom_range(80) - 8) * 256;
        span_px = $urandom_range(12) * 256 + 256;
        return tri_item(bx + $urandom_range(span_px), by + $urandom_range(span_px),
                        bx + $urandom_range(span_px), by + $urandom_range(span_px),
                        bx + $urandom_range(span_px), by + $urandom_range(span_px),
                        $urandom_range(40000) - 12000, $urandom_range(40000) - 12000,
                        $urandom_range(40000) - 12000, $urandom);
    endfunction

    function automatic strz_pkg::req_item_t noise_item();
        strz_pkg::req_item_t it;
        logic [287:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom};
        it = raw[$bits(strz_pkg::req_item_t)-1:0];
        it.operation = strz_pkg::OP_NONE;
        return it;
    endfunction

    initial
    begin
        strz_pkg::req_item_t it;
        int pick;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req_item  = '0;
        cfg_valid = 1'b0;
        cfg_index = strz_pkg::CFG_CLEAR_COLOR;
        cfg_data  = '0;
        calm      = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: framebuffer after reset, then the edge cases.
        send_item(read_item(12'd0));
        send_item(read_item(12'd4095));
        send_item(tri_item(0, 0, 64 * 256, 0, 0, 64 * 256, 1000, 2000, 3000, 32'hFF00FF00));
        send_item(read_item(12'd65));
        send_item(tri_item(-524288, -524288, 524287, -524288, 0, 524287,
                           -8388608, 8388607, 0, 32'hFFFFFFFF));
        send_item(read_item(12'd2080));
        // zero-width spans: all three vertices on one vertical line
        send_item(tri_item(10 * 256, 2 * 256, 10 * 256, 9 * 256, 10 * 256, 5 * 256,
                           -5000, -5000, -5000, 32'h12345678));
        // flat top edge and bottom vertex beyond the height
        send_item(tri_item(3 * 256, 60 * 256, 20 * 256, 60 * 256, 8 * 256, 90 * 256,
                           -9000, -9000, -9000, 32'hA5A5A5A5));
        send_item(tri_item(-300, -700, 5000, 200, 1200, 3000, 8388607, -8388608, 0, 32'h0));
        send_item(read_item(12'd3843));
        send_item(op_item(strz_pkg::OP_NONE));
        send_item(noise_item());
        drain();

        write_reg(strz_pkg::CFG_CLEAR_COLOR, 32'hDEADBEEF);
        write_reg(strz_pkg::CFG_CLEAR_DEPTH, 32'h00FF_8000);
        send_item(op_item(strz_pkg::OP_CLEAR));
        send_item(read_item(12'd1000));
        send_item(tri_item(0, 0, 30 * 256, 5 * 256, 4 * 256, 20 * 256, 0, 0, 0, 32'h1));
        drain();
        write_reg(strz_pkg::CFG_CLEAR_COLOR, 32'hFFFFFFFF);
        write_reg(strz_pkg::CFG_CLEAR_DEPTH, 32'h007F_FFFF);
        send_item(op_item(strz_pkg::OP_CLEAR));
        send_item(tri_item(0, 0, 30 * 256, 5 * 256, 4 * 256, 20 * 256,
                           8388607, 8388606, 8388607, 32'h2));
        send_item(read_item(12'd1));
        drain();
        write_reg(strz_pkg::CFG_CLEAR_COLOR, 32'h00000000);
        write_reg(strz_pkg::CFG_CLEAR_DEPTH, 32'hFF00_0000);

        // Random: mostly small triangles and reads, a few clears and full-frame draws.
        for (int n = 0; n < 140; n++)
        begin
            calm = (n >= 60 && n < 90);
            pick = $urandom_range(99);
            if (n == 45 || n == 100)
            begin
                drain();
                write_reg(strz_pkg::CFG_CLEAR_COLOR, $urandom);
                write_reg(strz_pkg::CFG_CLEAR_DEPTH, $urandom_range(60000) - 20000);
            end
            if (pick < 50)      it = small_tri();
            else if (pick < 85) it = read_item(12'($urandom));
            else if (pick < 91) it = op_item(strz_pkg::OP_CLEAR);
            else if (pick < 94) it = tri_item($urandom_range(24000) - 4000,
                                              $urandom_range(24000) - 4000,
                                              $urandom_range(24000) - 4000,
                                              $urandom_range(24000) - 4000,
                                              $urandom_range(24000) - 4000,
                                              $urandom_range(24000) - 4000,
                                              $urandom, $urandom, $urandom, $urandom);
            else                it = noise_item();
            send_item(it);
        end
        calm = 1'b0;
        drain();
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
